>>> design/hcbd_pkg.sv
// Shared types, codes and character helpers for the chunked body decoder.
// No dependencies; every other design file takes names from here by scope.
`default_nettype none

package hcbd_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned SIZE_BITS_DEF = 32;

  localparam logic [STATUS_W-1:0] STATUS_BUSY      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd2;

  localparam logic [1:0] SKIP_CNT = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_X_LC  = 8'h78;
  localparam logic [BYTE_W-1:0] CHAR_X_UC  = 8'h58;

  typedef enum logic [2:0] {
    PH_WS     = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_IGNORE = 3'd3,
    PH_DATA   = 3'd4,
    PH_SKIP   = 3'd5,
    PH_DONE   = 3'd6,
    PH_ERROR  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              body_start;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                out_valid;
    logic                last_of_chunk;
    logic [STATUS_W-1:0] status;
  } res_t;

  function automatic logic is_hex(input logic [BYTE_W-1:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // Value of a hex digit; only meaningful when is_hex() holds.
  function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR});
  endfunction

endpackage

`default_nettype wire

>>> design/hcbd_in_if.sv
// Input channel: raw body bytes with a body-start marker.
// Depends on hcbd_pkg for field widths.
`default_nettype none

interface hcbd_in_if;
  logic                             valid;
  logic                             ready;
  logic [hcbd_pkg::BYTE_W-1:0]      in_byte;
  logic                             body_start;

  modport source (output valid, output in_byte, output body_start, input ready);
  modport sink   (input valid, input in_byte, input body_start, output ready);
endinterface

`default_nettype wire

>>> design/hcbd_out_if.sv
// Result channel: one result per input byte (payload byte, flags, status).
// Depends on hcbd_pkg for field widths.
`default_nettype none

interface hcbd_out_if;
  logic                             valid;
  logic                             ready;
  logic [hcbd_pkg::BYTE_W-1:0]      out_byte;
  logic                             out_valid;
  logic                             last_of_chunk;
  logic [hcbd_pkg::STATUS_W-1:0]    status;

  modport source (output valid, output out_byte, output out_valid, output last_of_chunk,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input last_of_chunk,
                  input status, output ready);
endinterface

`default_nettype wire

>>> design/hcbd_in_stage.sv
// Input register stage: captures one request from the input channel.
// Depends on hcbd_pkg and hcbd_in_if.
`default_nettype none

module hcbd_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  hcbd_in_if.sink              in_ch,
  input  wire logic            take,    // downstream consumes the held item this cycle
  output hcbd_pkg::item_t      item,
  output logic                 item_valid
);

  logic            valid_r;
  hcbd_pkg::item_t item_r;

  assign in_ch.ready = !valid_r || take;
  assign item        = item_r;
  assign item_valid  = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.in_byte    <= in_ch.in_byte;
      item_r.body_start <= in_ch.body_start;
    end
  end

endmodule

`default_nettype wire

>>> design/hcbd_parse.sv
// Chunk decode state machine: size line parsing, payload count, trailing skip.
// Depends on hcbd_pkg. State advances once per consumed request.
`default_nettype none

module hcbd_parse #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire hcbd_pkg::item_t  item,
  output hcbd_pkg::res_t        res
);

  hcbd_pkg::phase_t     phase_r, phase_nxt, b_phase;
  logic                 cr_r, cr_nxt, b_cr;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt, b_acc;
  logic                 neg_r, neg_nxt, b_neg;
  logic                 lz_r, lz_nxt, b_lz;
  logic [SIZE_BITS-1:0] left_r, left_nxt, b_left;
  logic [1:0]           skip_r, skip_nxt, b_skip;

  logic [hcbd_pkg::BYTE_W-1:0] c;
  logic                 dig_ok;
  logic [3:0]           dig;
  logic                 ovf;
  logic [SIZE_BITS-1:0] acc_sh;
  logic [SIZE_BITS-1:0] left_dec;
  logic [1:0]           skip_dec;
  logic                 take_digit;

  // body_start restarts the decoder before this byte is handled
  always_comb begin
    if (item.body_start) begin
      b_phase = hcbd_pkg::PH_WS;
      b_cr    = 1'b0;
      b_acc   = '0;
      b_neg   = 1'b0;
      b_lz    = 1'b0;
      b_left  = '0;
      b_skip  = '0;
    end else begin
      b_phase = phase_r;
      b_cr    = cr_r;
      b_acc   = acc_r;
      b_neg   = neg_r;
      b_lz    = lz_r;
      b_left  = left_r;
      b_skip  = skip_r;
    end
  end

  assign c      = item.in_byte;
  assign dig_ok = hcbd_pkg::is_hex(c);
  assign dig    = hcbd_pkg::hex_val(c);
  // another digit overflows exactly when the top nibble is already in use
  assign ovf    = |b_acc[SIZE_BITS-1 -: 4];
  assign acc_sh = {b_acc[SIZE_BITS-5:0], dig};
  assign left_dec = (b_left != '0) ? (b_left - {{(SIZE_BITS-1){1'b0}}, 1'b1}) : b_left;
  assign skip_dec = (b_skip != '0) ? (b_skip - 2'd1) : b_skip;

  // next state
  always_comb begin
    phase_nxt  = b_phase;
    cr_nxt     = b_cr;
    acc_nxt    = b_acc;
    neg_nxt    = b_neg;
    lz_nxt     = b_lz;
    left_nxt   = b_left;
    skip_nxt   = b_skip;
    take_digit = 1'b0;
    case (b_phase)
      hcbd_pkg::PH_WS, hcbd_pkg::PH_SIGN, hcbd_pkg::PH_DIGITS, hcbd_pkg::PH_IGNORE: begin
        if (b_cr && (c == hcbd_pkg::CHAR_LF)) begin
          if (b_acc == '0) begin
            phase_nxt = hcbd_pkg::PH_DONE;
          end else begin
            left_nxt  = b_acc;
            phase_nxt = hcbd_pkg::PH_DATA;
          end
          cr_nxt = 1'b0;
        end else begin
          case (b_phase)
            hcbd_pkg::PH_WS: begin
              if (hcbd_pkg::is_space(c)) begin
                phase_nxt = hcbd_pkg::PH_WS;
              end else if (c == hcbd_pkg::CHAR_PLUS || c == hcbd_pkg::CHAR_MINUS) begin
                neg_nxt   = (c == hcbd_pkg::CHAR_MINUS);
                phase_nxt = hcbd_pkg::PH_SIGN;
              end else if (dig_ok) begin
                phase_nxt  = hcbd_pkg::PH_DIGITS;
                lz_nxt     = (dig == 4'd0);
                take_digit = 1'b1;
              end else begin
                phase_nxt = hcbd_pkg::PH_IGNORE;
              end
            end
            hcbd_pkg::PH_SIGN: begin
              if (dig_ok) begin
                phase_nxt  = hcbd_pkg::PH_DIGITS;
                lz_nxt     = (dig == 4'd0);
                take_digit = 1'b1;
              end else begin
                phase_nxt = hcbd_pkg::PH_IGNORE;
              end
            end
            hcbd_pkg::PH_DIGITS: begin
              if (dig_ok) begin
                lz_nxt     = 1'b0;
                take_digit = 1'b1;
              end else if ((c == hcbd_pkg::CHAR_X_LC || c == hcbd_pkg::CHAR_X_UC) && b_lz) begin
                lz_nxt = 1'b0;   // "0x" prefix
              end else begin
                phase_nxt = hcbd_pkg::PH_IGNORE;
              end
            end
            default: begin
            end
          endcase
          if (take_digit) begin
            if (ovf) begin
              phase_nxt = hcbd_pkg::PH_ERROR;
            end else begin
              acc_nxt = acc_sh;
              if (b_neg && (acc_sh != '0)) begin
                phase_nxt = hcbd_pkg::PH_ERROR;
              end
            end
          end
          if (phase_nxt != hcbd_pkg::PH_ERROR) begin
            cr_nxt = (c == hcbd_pkg::CHAR_CR);
          end
        end
      end
      hcbd_pkg::PH_DATA: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          skip_nxt  = hcbd_pkg::SKIP_CNT;
          phase_nxt = hcbd_pkg::PH_SKIP;
        end
      end
      hcbd_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = hcbd_pkg::PH_WS;
          cr_nxt    = 1'b0;
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          lz_nxt    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // result for this byte
  always_comb begin
    res.out_valid     = (b_phase == hcbd_pkg::PH_DATA);
    res.out_byte      = res.out_valid ? c : '0;
    res.last_of_chunk = res.out_valid && (left_dec == '0);
    case (phase_nxt)
      hcbd_pkg::PH_DONE:  res.status = hcbd_pkg::STATUS_DONE;
      hcbd_pkg::PH_ERROR: res.status = hcbd_pkg::STATUS_MALFORMED;
      default:            res.status = hcbd_pkg::STATUS_BUSY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcbd_pkg::PH_WS;
      cr_r    <= 1'b0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      lz_r    <= 1'b0;
      left_r  <= '0;
      skip_r  <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cr_r    <= cr_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      lz_r    <= lz_nxt;
      left_r  <= left_nxt;
      skip_r  <= skip_nxt;
    end
  end

  a_last_goes_skip: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.last_of_chunk |=> phase_r == hcbd_pkg::PH_SKIP)
    else $error("last payload byte did not lead to the trailing skip");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !item.body_start && phase_r == hcbd_pkg::PH_DONE |=> phase_r == hcbd_pkg::PH_DONE)
    else $error("completed body left the done phase without body_start");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == hcbd_pkg::PH_DATA |-> left_r != '0)
    else $error("payload phase with zero bytes left");

  a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == hcbd_pkg::PH_SKIP |-> skip_r != '0)
    else $error("skip phase with zero bytes left to skip");

endmodule

`default_nettype wire

>>> design/hcbd_out_stage.sv
// Result register stage: holds one result until the result channel takes it.
// Depends on hcbd_pkg and hcbd_out_if.
`default_nettype none

module hcbd_out_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  input  wire hcbd_pkg::res_t  res,
  output logic                 up_ready,
  hcbd_out_if.source           out_ch
);

  logic           valid_r;
  hcbd_pkg::res_t res_r;

  assign up_ready             = !valid_r || out_ch.ready;
  assign out_ch.valid         = valid_r;
  assign out_ch.out_byte      = res_r.out_byte;
  assign out_ch.out_valid     = res_r.out_valid;
  assign out_ch.last_of_chunk = res_r.last_of_chunk;
  assign out_ch.status        = res_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

>>> design/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked body decoder.
// Depends on hcbd_pkg, hcbd_in_if, hcbd_out_if, hcbd_in_stage, hcbd_parse, hcbd_out_stage.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   in_byte[7:0], body_start
//   out_ch   out  valid/ready   out_byte[7:0], out_valid, last_of_chunk, status[1:0]
//
// One result per input byte; one byte accepted per cycle when the output is drained.
// Each byte passes the input register, then decode logic into the result register.
// The decode state machine advances when a byte moves from input to result register.
// rst_n is synchronous; it empties both registers and returns to size-line parsing.
// A stalled output holds its result; the input keeps taking one more byte behind it.
`default_nettype none

module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hcbd_in_if.sink     in_ch,
  hcbd_out_if.source  out_ch
);

  hcbd_pkg::item_t item;
  logic            item_valid;
  hcbd_pkg::res_t  res;
  logic            up_ready;
  logic            adv;

  assign adv = item_valid && up_ready;

  hcbd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (adv),
    .item       (item),
    .item_valid (item_valid)
  );

  hcbd_parse #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item),
    .res   (res)
  );

  hcbd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (item_valid),
    .res      (res),
    .up_ready (up_ready),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

>>> tb/http_chunked_body_decoder_tb.sv
// Testbench for the chunked body decoder: directed rows, then random bodies.
// Depends on hcbd_pkg, hcbd_in_if, hcbd_out_if and http_chunked_body_decoder.
`default_nettype none

module http_chunked_body_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbd_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 950;
  localparam logic [63:0] SIZE_MAX = (64'd1 << SIZE_BITS_DEF) - 64'd1;

  localparam res_t R_BUSY = '{8'h00, 1'b0, 1'b0, STATUS_BUSY};
  localparam res_t R_DONE = '{8'h00, 1'b0, 1'b0, STATUS_DONE};
  localparam res_t R_BAD  = '{8'h00, 1'b0, 1'b0, STATUS_MALFORMED};

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              st;
    logic              typed;
    res_t              want;
  } dir_row_t;

  // Hand-written expectations only where obvious; the rest go to the predictor.
  localparam dir_row_t DIR_TABLE [0:25] = '{
    '{CHAR_SPACE, 1'b1, 1'b1, R_BUSY},                              // fresh body
    '{CHAR_PLUS,  1'b0, 1'b0, R_BUSY},
    '{"0",        1'b0, 1'b0, R_BUSY},
    '{CHAR_X_UC,  1'b0, 1'b0, R_BUSY},                              // 0X prefix
    '{"2",        1'b0, 1'b0, R_BUSY},
    '{CHAR_CR,    1'b0, 1'b0, R_BUSY},
    '{CHAR_LF,    1'b0, 1'b0, R_BUSY},
    '{8'h00,      1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, STATUS_BUSY}},
    '{8'hFF,      1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, STATUS_BUSY}},
    '{CHAR_CR,    1'b0, 1'b0, R_BUSY},                              // trailing pair
    '{CHAR_LF,    1'b0, 1'b0, R_BUSY},
    '{CHAR_LF,    1'b0, 1'b0, R_BUSY},                              // lone LF = blank
    '{CHAR_CR,    1'b0, 1'b0, R_BUSY},                              // empty size line
    '{CHAR_LF,    1'b0, 1'b1, R_DONE},
    '{CHAR_MINUS, 1'b1, 1'b0, R_BUSY},
    '{"0",        1'b0, 1'b0, R_BUSY},                              // "-0" still fine
    '{"7",        1'b0, 1'b1, R_BAD},                               // negative size
    '{"f",        1'b1, 1'b0, R_BUSY},
    '{"f",        1'b0, 1'b0, R_BUSY},
    '{"f",        1'b0, 1'b0, R_BUSY},
    '{"f",        1'b0, 1'b0, R_BUSY},
    '{"f",        1'b0, 1'b0, R_BUSY},
    '{"f",        1'b0, 1'b0, R_BUSY},
    '{"f",        1'b0, 1'b0, R_BUSY},
    '{"f",        1'b0, 1'b0, R_BUSY},                              // largest size
    '{"F",        1'b0, 1'b1, R_BAD}                                // size overflow
  };

  logic clk;
  logic rst_n;

  hcbd_in_if  in_ch();
  hcbd_out_if out_ch();

  http_chunked_body_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // decoder image
  phase_t      dec_phase;
  logic        dec_cr;
  logic [63:0] dec_size;
  logic        dec_neg;
  logic        dec_lone_zero;
  logic [63:0] dec_remain;
  logic [1:0]  dec_skip;

  res_t pending_results[$];
  logic cur_typed;
  res_t cur_want;
  bit   start_pending;
  bit   no_idle;
  bit   held_off;
  int   sent_cnt;
  int   got_cnt;
  int   err_cnt;
  int   cycle_cnt;

  function automatic int digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT ||
           c == CHAR_FF || c == CHAR_CR;
  endfunction

  function automatic void start_size_line();
    dec_phase     = PH_WS;
    dec_cr        = 1'b0;
    dec_size      = '0;
    dec_neg       = 1'b0;
    dec_lone_zero = 1'b0;
  endfunction

  function automatic void clear_decoder();
    start_size_line();
    dec_remain = '0;
    dec_skip   = '0;
  endfunction

  function automatic void push_digit(input int d);
    logic [63:0] dv;
    dv = 64'(d);
    if (dec_size > ((SIZE_MAX - dv) >> 4)) begin
      dec_phase = PH_ERROR;
    end else begin
      dec_size = ((dec_size << 4) + dv) & SIZE_MAX;
      if (dec_neg && dec_size != 0) dec_phase = PH_ERROR;
    end
  endfunction

  function automatic res_t decode_byte(input logic [7:0] c, input logic st);
    res_t r;
    int   d;
    r = '0;
    if (st) clear_decoder();
    case (dec_phase)
      PH_WS, PH_SIGN, PH_DIGITS, PH_IGNORE: begin
        if (dec_cr && c == CHAR_LF) begin
          if (dec_size == 0) begin
            dec_phase = PH_DONE;
          end else begin
            dec_remain = dec_size;
            dec_phase  = PH_DATA;
          end
          dec_cr = 1'b0;
        end else begin
          d = digit_value(c);
          case (dec_phase)
            PH_WS: begin
              if (is_blank(c)) begin
              end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                dec_neg   = (c == CHAR_MINUS);
                dec_phase = PH_SIGN;
              end else if (d >= 0) begin
                dec_phase     = PH_DIGITS;
                dec_lone_zero = (d == 0);
                push_digit(d);
              end else begin
                dec_phase = PH_IGNORE;
              end
            end
            PH_SIGN: begin
              if (d >= 0) begin
                dec_phase     = PH_DIGITS;
                dec_lone_zero = (d == 0);
                push_digit(d);
              end else begin
                dec_phase = PH_IGNORE;
              end
            end
            PH_DIGITS: begin
              if (d >= 0) begin
                dec_lone_zero = 1'b0;
                push_digit(d);
              end else if ((c == CHAR_X_LC || c == CHAR_X_UC) && dec_lone_zero) begin
                dec_lone_zero = 1'b0;
              end else begin
                dec_phase = PH_IGNORE;
              end
            end
            default: begin
            end
          endcase
          if (dec_phase != PH_ERROR) dec_cr = (c == CHAR_CR);
        end
      end
      PH_DATA: begin
        r.out_byte  = c;
        r.out_valid = 1'b1;
        if (dec_remain != 0) dec_remain = dec_remain - 64'd1;
        if (dec_remain == 0) begin
          r.last_of_chunk = 1'b1;
          dec_skip        = SKIP_CNT;
          dec_phase       = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (dec_skip != 0) dec_skip = dec_skip - 2'd1;
        if (dec_skip == 0) start_size_line();
      end
      default: begin
      end
    endcase
    r.status = (dec_phase == PH_DONE)  ? STATUS_DONE :
               (dec_phase == PH_ERROR) ? STATUS_MALFORMED : STATUS_BUSY;
    return r;
  endfunction

  // Predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("http_chunked_body_decoder test failed");
      $finish;
    end
    if (!rst_n) begin
      clear_decoder();
    end else begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        want = decode_byte(in_ch.in_byte, in_ch.body_start);
        if (cur_typed) want = cur_want;
        pending_results.push_back(want);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got_cnt++;
        got = '{out_ch.out_byte, out_ch.out_valid, out_ch.last_of_chunk, out_ch.status};
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing pending: byte=%h valid=%b last=%b status=%0d",
                   $time, got.out_byte, got.out_valid, got.last_of_chunk, got.status);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
              got.last_of_chunk !== want.last_of_chunk || got.status !== want.status) begin
            $display("%0t: expected byte=%h valid=%b last=%b status=%0d, actual byte=%h valid=%b last=%b status=%0d",
                     $time, want.out_byte, want.out_valid, want.last_of_chunk, want.status,
                     got.out_byte, got.out_valid, got.last_of_chunk, got.status);
            err_cnt++;
          end
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int w;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 6);
      if (!held_off && got_cnt >= 300) begin
        w        = 120;
        held_off = 1'b1;
      end
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  task automatic offer(input logic [7:0] b, input logic st, input logic typed,
                       input res_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.body_start <= st;
    cur_typed        <= typed;
    cur_want         <= want;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent_cnt++;
  endtask

  task automatic emit(input logic [7:0] b);
    offer(b, start_pending, 1'b0, R_BUSY);
    start_pending = 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 4))
      0: return CHAR_TAB;
      1: return CHAR_VT;
      2: return CHAR_FF;
      3: return CHAR_LF;
      default: return CHAR_SPACE;
    endcase
  endfunction

  task automatic send_size_line(input int unsigned size);
    logic [7:0]  digs[$];
    int unsigned v;
    repeat ($urandom_range(0, 2)) emit(blank_char());
    case ($urandom_range(0, 15))
      0, 1: emit(CHAR_PLUS);
      2: if (size == 0) emit(CHAR_MINUS);
      default: begin
      end
    endcase
    if ($urandom_range(0, 5) == 0) begin
      emit("0");
      emit($urandom_range(0, 1) ? CHAR_X_LC : CHAR_X_UC);
    end
    repeat ($urandom_range(0, 1)) emit("0");
    if (size != 0 || $urandom_range(0, 2) != 0) begin
      v = size;
      do begin
        digs.push_front(hex_char(v % 16));
        v = v / 16;
      end while (v != 0);
      foreach (digs[i]) emit(digs[i]);
    end
    // lone CR after the digits just ends them
    if ($urandom_range(0, 9) == 0) begin
      emit(CHAR_CR);
      emit(CHAR_SPACE);
    end
    if ($urandom_range(0, 3) == 0) begin
      emit(";");
      repeat ($urandom_range(1, 4)) emit(8'($urandom_range(8'h21, 8'h7E)));
    end
    emit(CHAR_CR);
    emit(CHAR_LF);
  endtask

  task automatic send_body();
    int unsigned size;
    int          n;
    start_pending = 1'b1;
    n = $urandom_range(0, 3);
    for (int k = 0; k <= n; k++) begin
      size = (k == n) ? 0 :
             ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      send_size_line(size);
      repeat (size) emit(8'($urandom_range(0, 255)));
      if (size != 0) begin
        if ($urandom_range(0, 5) == 0) begin
          emit(8'($urandom_range(0, 255)));
          emit(8'($urandom_range(0, 255)));
        end else begin
          emit(CHAR_CR);
          emit(CHAR_LF);
        end
      end
    end
    // trailers and junk after the end are ignored
    repeat ($urandom_range(0, 4)) emit(8'($urandom_range(0, 255)));
  endtask

  // Body cut short in its data; the next body restarts the decoder.
  task automatic send_cut_body();
    int unsigned size;
    start_pending = 1'b1;
    size = $urandom_range(5, 20);
    send_size_line(size);
    repeat ($urandom_range(0, size - 1)) emit(8'($urandom_range(0, 255)));
  endtask

  task automatic send_bad_line();
    start_pending = 1'b1;
    repeat ($urandom_range(0, 2)) emit(blank_char());
    if ($urandom_range(0, 1) == 0) begin
      emit(CHAR_MINUS);
      repeat ($urandom_range(0, 1)) emit("0");
      emit(hex_char($urandom_range(1, 15)));
      repeat ($urandom_range(0, 2)) emit(hex_char($urandom_range(0, 15)));
    end else begin
      emit(hex_char($urandom_range(1, 15)));
      repeat ($urandom_range(8, 10)) emit(hex_char($urandom_range(0, 15)));
    end
    repeat ($urandom_range(0, 4)) emit(8'($urandom_range(0, 255)));
    emit(CHAR_CR);
    emit(CHAR_LF);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0: return CHAR_CR;
      1: return CHAR_LF;
      2: return hex_char($urandom_range(0, 15));
      3: return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_noise();
    repeat ($urandom_range(4, 16)) offer(noise_byte(), $urandom_range(0, 7) == 0, 1'b0, R_BUSY);
  endtask

  initial begin
    bit drained_once;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    in_ch.body_start = 1'b0;
    cur_typed        = 1'b0;
    cur_want         = R_BUSY;
    no_idle          = 1'b0;
    held_off         = 1'b0;
    start_pending    = 1'b0;
    drained_once     = 1'b0;
    sent_cnt         = 0;
    got_cnt          = 0;
    err_cnt          = 0;
    cycle_cnt        = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TABLE[i])
      offer(DIR_TABLE[i].b, DIR_TABLE[i].st, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    wait_drained();

    while (sent_cnt < RAND_ITEMS) begin
      if (!drained_once && sent_cnt >= 500) begin
        wait_drained();
        drained_once = 1'b1;
      end
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        7: send_noise();
        8: send_cut_body();
        9: send_bad_line();
        default: send_body();
      endcase
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("http_chunked_body_decoder test passed");
    end else begin
      $display("http_chunked_body_decoder test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
design/hcbd_pkg.sv
design/hcbd_in_if.sv
design/hcbd_out_if.sv
design/hcbd_in_stage.sv
design/hcbd_parse.sv
design/hcbd_out_stage.sv
design/http_chunked_body_decoder.sv
tb/http_chunked_body_decoder_tb.sv
